/* sv/assert_macros.svh */
// Assertion macros used by the word packer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define BQWP_ASSERT_HOLDS(NAME, CLK, RSTN, PROP, MSG) \
    NAME: assert property (@(posedge CLK) disable iff (!RSTN) PROP) else $error(MSG);

// Antecedent in one cycle implies consequent in the next.
`define BQWP_ASSERT_NEXT(NAME, CLK, RSTN, ANTE, CONS, MSG) \
    NAME: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |=> (CONS)) else $error(MSG);

`endif

/* sv/bqwp_pkg.sv */
// Shared constants and types for the quadrature step word packer.
package bqwp_pkg;

    localparam int STATES_PER_TICK = 20;
    localparam int WORD_BITS       = 32;
    localparam int FRAC_BITS       = 8;

    localparam int POS_W  = 32;
    localparam int EMIT_W = 24;
    localparam int OUT_W  = 32;

    localparam logic [1:0] PH_FWD = 2'd3;
    localparam logic [1:0] PH_BWD = 2'd1;

    typedef struct packed {
        logic       valid;
        logic       fwd;
        logic       clamp;
        logic [1:0] phase;
    } cell_ctl_t;

endpackage

/* sv/bqwp_cell.sv */
// One state slot of the tick: Bresenham accumulate, phase step, slot write.
module bqwp_cell #(
    parameter int STATES = bqwp_pkg::STATES_PER_TICK,
    parameter int SLOT   = 0
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           adv,
    input  bqwp_pkg::cell_ctl_t            ctl_in,
    input  logic [$clog2(STATES+1)-1:0]    n_in,
    input  logic [$clog2(2*STATES)-1:0]    acc_in,
    input  logic [2*STATES-1:0]            vec_in,
    output bqwp_pkg::cell_ctl_t            ctl_out,
    output logic [$clog2(STATES+1)-1:0]    n_out,
    output logic [$clog2(2*STATES)-1:0]    acc_out,
    output logic [2*STATES-1:0]            vec_out
);

    localparam int NW = $clog2(STATES + 1);
    localparam int AW = $clog2(2 * STATES);
    localparam int VW = 2 * STATES;

    bqwp_pkg::cell_ctl_t ctl_reg;
    bqwp_pkg::cell_ctl_t ctl_next;
    logic [NW-1:0]       n_reg;
    logic [AW-1:0]       acc_reg;
    logic [AW-1:0]       acc_next;
    logic [VW-1:0]       vec_reg;
    logic [VW-1:0]       vec_next;
    logic [AW-1:0]       acc_sum;
    logic                hit;

    always_comb
    begin
        acc_sum  = acc_in + AW'(n_in);
        hit      = (acc_sum >= AW'(STATES));
        acc_next = hit ? (acc_sum - AW'(STATES)) : acc_sum;
        ctl_next = ctl_in;
        if (hit)
        begin
            ctl_next.phase = ctl_in.phase + (ctl_in.fwd ? bqwp_pkg::PH_FWD : bqwp_pkg::PH_BWD);
        end
        vec_next = vec_in;
        vec_next[2*SLOT +: 2] = ctl_next.phase;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (adv)
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            n_reg   <= n_in;
            acc_reg <= acc_next;
            vec_reg <= vec_next;
        end
    end

    assign ctl_out = ctl_reg;
    assign n_out   = n_reg;
    assign acc_out = acc_reg;
    assign vec_out = vec_reg;

endmodule

/* sv/bqwp_packer.sv */
// Word packer: splits each tick's phase vector into output words.
`include "assert_macros.svh"

module bqwp_packer #(
    parameter int STATES    = bqwp_pkg::STATES_PER_TICK,
    parameter int WORD_BITS = bqwp_pkg::WORD_BITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  bqwp_pkg::cell_ctl_t         tick_ctl,
    input  logic [2*STATES-1:0]         tick_vec,
    output logic                        ready,
    output logic                        word_valid,
    input  logic                        word_stall,
    output logic [bqwp_pkg::OUT_W-1:0]  packed_word,
    output logic                        last_of_tick,
    output logic                        clamped
);

    localparam int E   = (WORD_BITS + 1) / 2;
    localparam int FW  = $clog2(E);
    localparam int NDW = $clog2(E + 1);
    localparam int RW  = $clog2(STATES + 1);
    localparam int CW  = (RW > NDW) ? RW : NDW;
    localparam int VW  = 2 * STATES;
    localparam int OW  = bqwp_pkg::OUT_W;

    logic           busy_reg, busy_next;
    logic [RW-1:0]  rem_reg, rem_next;
    logic [VW-1:0]  tv_reg, tv_next;
    logic           tclamp_reg, tclamp_next;
    logic [OW-1:0]  partial_reg, partial_next;
    logic [FW-1:0]  fill_reg, fill_next;
    logic           word_valid_reg, word_valid_next;
    logic [OW-1:0]  word_reg;
    logic           last_reg;
    logic           clamp_reg;

    logic [NDW-1:0] need;
    logic [CW-1:0]  after;
    logic           complete;
    logic           room;
    logic           step;
    logic           emit;
    logic           finish;
    logic           load;
    logic           last_word;
    logic [VW-1:0]  tv_m;
    logic [VW-1:0]  tv_sh;
    logic [OW-1:0]  word_cat;
    logic [OW-1:0]  deposit;

    always_comb
    begin
        need      = NDW'(E) - NDW'(fill_reg);
        complete  = (CW'(rem_reg) >= CW'(need));
        after     = CW'(rem_reg) - CW'(need);
        last_word = (after < CW'(E));
        room      = !word_valid_reg || !word_stall;
        step      = busy_reg && (!complete || room);
        emit      = step && complete;
        finish    = step && (!complete || last_word);
        ready     = !busy_reg || finish;
        load      = ready && tick_ctl.valid;
        tv_m      = tv_reg & ~({VW{1'b1}} << {need, 1'b0});
        tv_sh     = tv_reg >> {need, 1'b0};
        word_cat  = partial_reg | (OW'(tv_m) << {fill_reg, 1'b0});
        deposit   = partial_reg | (OW'(tv_reg) << {fill_reg, 1'b0});
    end

    always_comb
    begin
        busy_next    = busy_reg;
        rem_next     = rem_reg;
        tv_next      = tv_reg;
        tclamp_next  = tclamp_reg;
        partial_next = partial_reg;
        fill_next    = fill_reg;
        if (step)
        begin
            if (complete)
            begin
                if (last_word)
                begin
                    partial_next = OW'(tv_sh);
                    fill_next    = FW'(after);
                    busy_next    = 1'b0;
                end
                else
                begin
                    partial_next = '0;
                    fill_next    = '0;
                    rem_next     = RW'(after);
                    tv_next      = tv_sh;
                end
            end
            else
            begin
                partial_next = deposit;
                fill_next    = FW'(CW'(fill_reg) + CW'(rem_reg));
                busy_next    = 1'b0;
            end
        end
        if (load)
        begin
            busy_next   = 1'b1;
            rem_next    = RW'(STATES);
            tv_next     = tick_vec;
            tclamp_next = tick_ctl.clamp;
        end
    end

    always_comb
    begin
        if (emit)
        begin
            word_valid_next = 1'b1;
        end
        else if (!word_stall)
        begin
            word_valid_next = 1'b0;
        end
        else
        begin
            word_valid_next = word_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            rem_reg        <= '0;
            partial_reg    <= '0;
            fill_reg       <= '0;
            word_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg       <= busy_next;
            rem_reg        <= rem_next;
            partial_reg    <= partial_next;
            fill_reg       <= fill_next;
            word_valid_reg <= word_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tv_reg     <= tv_next;
        tclamp_reg <= tclamp_next;
        if (emit)
        begin
            word_reg  <= word_cat;
            last_reg  <= last_word;
            clamp_reg <= tclamp_reg;
        end
    end

    assign word_valid   = word_valid_reg;
    assign packed_word  = word_reg;
    assign last_of_tick = last_reg;
    assign clamped      = clamp_reg;

    `BQWP_ASSERT_HOLDS(a_fill_range, clk, rst_n, int'(fill_reg) < E, "fill past word size")
    `BQWP_ASSERT_HOLDS(a_busy_rem, clk, rst_n, busy_reg |-> (rem_reg != '0), "busy with no states left")
    `BQWP_ASSERT_NEXT(a_short_done, clk, rst_n, busy_reg && !complete, !busy_reg || (rem_reg == RW'(STATES)), "short tick did not retire")
    `BQWP_ASSERT_NEXT(a_emit_last, clk, rst_n, emit && last_word, word_valid && last_of_tick, "final word of tick not flagged")

endmodule

/* sv/bresenham_quadrature_word_packer_core.sv */
// Top level: tick intake, Bresenham cell chain and word packer.
//
//  channel   | handshake                | payload
//  ----------+--------------------------+------------------------------------------
//  target    | target_valid/target_stall | target_position
//  word      | word_valid/word_stall     | packed_word, last_of_tick, clamped
//
// A tick enters the launch stage at once; the emitted position and phase update at intake.
// The tick then passes through the cell chain to the packer, one cell per cycle while the chain advances.
// The packer completes 1-2 words per tick at defaults and takes a new tick only as it finishes the last one.
// A stalled word output backs up the packer, which freezes the whole cell chain.
// Reset clears position, phase, the partial word and all valid flags.
module bresenham_quadrature_word_packer_core #(
    parameter int STATES_PER_TICK = bqwp_pkg::STATES_PER_TICK,
    parameter int WORD_BITS       = bqwp_pkg::WORD_BITS,
    parameter int FRAC_BITS       = bqwp_pkg::FRAC_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                target_valid,
    output logic                                target_stall,
    input  logic signed [bqwp_pkg::POS_W-1:0]   target_position,
    output logic                                word_valid,
    input  logic                                word_stall,
    output logic [bqwp_pkg::OUT_W-1:0]          packed_word,
    output logic                                last_of_tick,
    output logic                                clamped
);

    localparam int S  = STATES_PER_TICK;
    localparam int NW = $clog2(S + 1);
    localparam int AW = $clog2(2 * S);
    localparam int VW = 2 * S;
    localparam int EW = bqwp_pkg::EMIT_W;
    localparam int PW = (EW + FRAC_BITS > bqwp_pkg::POS_W) ? EW + FRAC_BITS : bqwp_pkg::POS_W;
    localparam int DW = PW + 1;

    logic [EW-1:0]       emitted_reg, emitted_next;
    logic [1:0]          phase_reg, phase_next;
    bqwp_pkg::cell_ctl_t lau_ctl_reg, lau_ctl_next;
    logic [NW-1:0]       lau_n_reg;

    logic signed [DW-1:0] tgt_x;
    logic signed [DW-1:0] emit_fix;
    logic signed [DW-1:0] diff;
    logic [DW-1:0]        mag;
    logic [DW-1:0]        owed;
    logic                 fwd;
    logic                 clamp;
    logic [NW-1:0]        n_issue;
    logic [1:0]           n_lo;
    logic                 adv;
    logic                 accept;
    logic                 pk_ready;

    bqwp_pkg::cell_ctl_t ctl_c [S+1];
    logic [NW-1:0]       n_c   [S+1];
    logic [AW-1:0]       acc_c [S+1];
    logic [VW-1:0]       vec_c [S+1];

    assign adv          = pk_ready || !ctl_c[S].valid;
    assign target_stall = !adv;
    assign accept       = target_valid && adv;

    always_comb
    begin
        tgt_x    = DW'(target_position);
        emit_fix = DW'($signed(emitted_reg)) <<< FRAC_BITS;
        diff     = tgt_x - emit_fix;
        fwd      = !diff[DW-1];
        mag      = fwd ? $unsigned(diff) : $unsigned(-diff);
        owed     = mag >> FRAC_BITS;
        clamp    = (owed > DW'(S));
        n_issue  = clamp ? NW'(S) : NW'(owed);
        n_lo     = 2'(n_issue);

        emitted_next = emitted_reg;
        phase_next   = phase_reg;
        if (accept)
        begin
            emitted_next = fwd ? (emitted_reg + EW'(n_issue)) : (emitted_reg - EW'(n_issue));
            phase_next   = phase_reg + (fwd ? 2'(n_lo * bqwp_pkg::PH_FWD)
                                            : 2'(n_lo * bqwp_pkg::PH_BWD));
        end

        lau_ctl_next.valid = accept;
        lau_ctl_next.fwd   = fwd;
        lau_ctl_next.clamp = clamp;
        lau_ctl_next.phase = phase_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emitted_reg <= '0;
            phase_reg   <= '0;
            lau_ctl_reg <= '0;
        end
        else
        begin
            emitted_reg <= emitted_next;
            phase_reg   <= phase_next;
            if (adv)
            begin
                lau_ctl_reg <= lau_ctl_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lau_n_reg <= n_issue;
        end
    end

    assign ctl_c[0] = lau_ctl_reg;
    assign n_c[0]   = lau_n_reg;
    assign acc_c[0] = '0;
    assign vec_c[0] = '0;

    for (genvar i = 0; i < S; i++)
    begin : g_cell
        bqwp_cell #(
            .STATES (S),
            .SLOT   (i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .ctl_in  (ctl_c[i]),
            .n_in    (n_c[i]),
            .acc_in  (acc_c[i]),
            .vec_in  (vec_c[i]),
            .ctl_out (ctl_c[i+1]),
            .n_out   (n_c[i+1]),
            .acc_out (acc_c[i+1]),
            .vec_out (vec_c[i+1])
        );
    end

    bqwp_packer #(
        .STATES    (S),
        .WORD_BITS (WORD_BITS)
    ) u_packer (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick_ctl     (ctl_c[S]),
        .tick_vec     (vec_c[S]),
        .ready        (pk_ready),
        .word_valid   (word_valid),
        .word_stall   (word_stall),
        .packed_word  (packed_word),
        .last_of_tick (last_of_tick),
        .clamped      (clamped)
    );

endmodule
